### src/mhfb_pkg.sv
// Shared types and constants for the multicast hash filter builder.
// Holds the item/result structs, the queue command, and the CRC-32 hash tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhfb_pkg;

	localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
	localparam int          ADDR_W    = 48;
	localparam int          COUNT_W   = 12;
	localparam int          IDX_W     = 6;
	localparam int          HALF_W    = 32;
	localparam int          CFG_IDX_W = 1;
	localparam int          CFG_DATA_W = 12;
	localparam logic [COUNT_W-1:0] FILTER_LIMIT_RST = 12'd32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ALL   = 1'd1;

	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic [COUNT_W-1:0] list_count;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  hash_index;
		logic [HALF_W-1:0] filter_low;
		logic [HALF_W-1:0] filter_high;
		logic              all_accepted;
	} result_t;

	// Classified command handed from front to back
	typedef struct packed {
		logic [IDX_W-1:0] hash_index;
		logic             set_bit;
		logic             over;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	// Bit-serial CRC, LSB-first data; only evaluated at elaboration
	function automatic logic [31:0] crc_run(logic [31:0] init, logic [ADDR_W-1:0] data);
		logic [31:0] crc;
		logic        top;
		crc = init;
		for (int i = 0; i < ADDR_W; i++) begin
			top = crc[31];
			crc = {crc[30:0], 1'b0};
			if (top ^ data[i]) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	// Per output bit: which address bits feed its parity
	function automatic logic [IDX_W-1:0][ADDR_W-1:0] hash_masks();
		logic [IDX_W-1:0][ADDR_W-1:0] m;
		logic [31:0]                  c;
		m = '0;
		for (int b = 0; b < ADDR_W; b++) begin
			c = crc_run(32'd0, ADDR_W'(1) << b);
			for (int k = 0; k < IDX_W; k++) begin
				m[k][b] = c[32-IDX_W+k];
			end
		end
		return m;
	endfunction

	localparam logic [31:0] CRC_OF_ZERO = crc_run(32'hFFFF_FFFF, '0);
	localparam logic [IDX_W-1:0][ADDR_W-1:0] HASH_MASK = hash_masks();
	localparam logic [IDX_W-1:0] HASH_INIT = CRC_OF_ZERO[31:32-IDX_W];

	// Top six CRC bits as one parity tree per bit
	function automatic logic [IDX_W-1:0] hash_of(logic [ADDR_W-1:0] addr);
		logic [IDX_W-1:0] idx;
		for (int k = 0; k < IDX_W; k++) begin
			idx[k] = HASH_INIT[k] ^ (^(addr & HASH_MASK[k]));
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

### src/mhfb_front.sv
// Front end: accepts address items, hashes them and classifies against the limit.
// Depends on mhfb_pkg; pushes cmd_t commands into mhfb_queue.
`timescale 1ns / 1ps
`default_nettype none

module mhfb_front
	import mhfb_pkg::*;
(
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire item_t                      item,
	input  wire logic [COUNT_W-1:0]         filter_limit,
	input  wire queue_status_t              q_status,
	output logic                            push,
	output cmd_t                            push_cmd
);

	logic over;

	assign over       = item.list_count > filter_limit;
	assign item_stall = q_status.full;
	assign push       = item_valid && !q_status.full;

	always_comb begin
		push_cmd.hash_index = hash_of(item.address);
		push_cmd.over       = over;
		// empty list hashes nothing
		push_cmd.set_bit    = !over && (item.list_count != '0);
	end

endmodule

`default_nettype wire

### src/mhfb_queue.sv
// Small FIFO of classified commands between front and back.
// Depends on mhfb_pkg for cmd_t and queue_status_t.
`timescale 1ns / 1ps
`default_nettype none

module mhfb_queue
	import mhfb_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire cmd_t    push_cmd,
	input  wire logic    pop,
	output cmd_t         head,
	output queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign head         = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/mhfb_back.sv
// Back end: applies commands to the 64-bit hash filter and registers the result.
// Depends on mhfb_pkg; pops commands from mhfb_queue.
`timescale 1ns / 1ps
`default_nettype none

module mhfb_back
	import mhfb_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          head,
	input  wire queue_status_t q_status,
	input  wire logic          accept_all,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_stall,
	output result_t            result
);

	logic [2*HALF_W-1:0] filter_q;
	logic [2*HALF_W-1:0] filter_next;
	logic [2*HALF_W-1:0] effective;
	logic                all_on;
	logic                result_valid_q;
	result_t             result_q;

	assign pop = !q_status.empty && (!result_valid_q || !result_stall);

	always_comb begin
		filter_next = filter_q;
		if (head.set_bit) begin
			filter_next = filter_q | ((2*HALF_W)'(1) << head.hash_index);
		end
		all_on    = head.over || accept_all;
		effective = all_on ? '1 : filter_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				filter_q       <= filter_next;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.hash_index   <= head.hash_index;
			result_q.filter_low   <= effective[HALF_W-1:0];
			result_q.filter_high  <= effective[2*HALF_W-1:HALF_W];
			result_q.all_accepted <= all_on;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### src/multicast_hash_filter_builder.sv
// Multicast hash filter builder: CRC-32 based 64-bit multicast hash filter.
// Depends on mhfb_pkg, mhfb_front, mhfb_queue and mhfb_back.
//
// Usage:
//   item channel (item_valid / item_stall / item): one multicast address plus
//   the length of its list per transaction. The address is hashed with the
//   Ethernet CRC-32 and the top six CRC bits pick one bit of the filter.
//   result channel (result_valid / result_stall / result): one transaction per
//   item, in order, with the hash index and the filter to program.
//   cfg port (cfg_we / cfg_index / cfg_data): filter_limit at index 0,
//   accept_all at index 1. Write only while the block is idle.
// Path: the command is written into the queue at the accepting edge, then popped
//   into the output register, which raises result_valid, once that register is
//   empty or its result is being taken.
// Throughput: one item per cycle while the queue has room; the hash is a parity
//   tree per index bit and the filter update is a single OR, both combinational.
// Reset: filter clears to zero, filter_limit returns to 32, accept_all to 0,
//   the queue and output register empty.
// Stall: a stalled result holds in the output register; the queue absorbs
//   up to QUEUE_DEPTH more items, then item_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module multicast_hash_filter_builder
	import mhfb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [COUNT_W-1:0] filter_limit_q;
	logic               accept_all_q;
	queue_status_t      q_status;
	logic               push;
	logic               pop;
	cmd_t               push_cmd;
	cmd_t               head;

	// Configuration registers; writes to unused indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_limit_q <= FILTER_LIMIT_RST;
			accept_all_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_LIMIT: filter_limit_q <= cfg_data[COUNT_W-1:0];
				REG_ACCEPT_ALL:   accept_all_q   <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Hash and classify each incoming transaction
	mhfb_front u_front (
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.filter_limit (filter_limit_q),
		.q_status     (q_status),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	// Decouple front and back
	mhfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// Update the filter and drive the result register
	mhfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.accept_all   (accept_all_q),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// A popped command always lands in the output register
	a_pop_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result_valid)
		else $error("popped command did not produce a result");

	// All-accept reports must carry an all-ones filter
	a_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.all_accepted) |->
		(result.filter_low == '1 && result.filter_high == '1))
		else $error("all_accepted without all-ones filter");

	// Queue cannot be empty and full at once, and never pops while empty
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.empty && q_status.full) && !(pop && q_status.empty))
		else $error("queue status inconsistent");

	// Front pushes only when the queue has room
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");

endmodule

`default_nettype wire

### tb/tb_multicast_hash_filter_builder.sv
// Self-checking testbench for the multicast hash filter builder.
// Depends on mhfb_pkg (item_t, result_t, register indexes) and the RTL top.
// Predicts the CRC-32 hash index and effective 64-bit filter per transaction.
`timescale 1ns / 1ps

module tb_multicast_hash_filter_builder;
	import mhfb_pkg::*;

	localparam logic [31:0] ETH_CRC_POLY = 32'h04C1_1DB7;
	localparam int CYCLE_LIMIT = 100000;
	localparam int SHOWN_MISMATCHES = 10;

	// Clock, reset and every block input start at known values
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	item_t item = '0;
	logic result_stall = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic item_stall;
	logic result_valid;
	result_t result;

	// Predictor state: stored filter plus a shadow of both registers
	logic [63:0] filter_bits = '0;
	logic [11:0] limit_setting = 12'd32;
	logic promisc_mode = 1'b0;

	item_t queued_addresses[$];
	result_t pending_reports[$];

	// Idle percentages, changed per phase by the stimulus process
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned failures = 0;
	int unsigned cycle_count = 0;
	logic [47:0] last_address = '0;

	multicast_hash_filter_builder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Ethernet CRC-32 over six bytes, data LSB-first, no final inversion;
	// the top six bits pick the filter bit.
	function automatic logic [5:0] crc_hash_index(logic [47:0] mac);
		logic [31:0] crc;
		logic fb;
		crc = '1;
		for (int i = 0; i < 48; i++) begin
			fb = crc[31] ^ mac[i];
			crc = {crc[30:0], 1'b0};
			if (fb) begin
				crc = crc ^ ETH_CRC_POLY;
			end
		end
		return crc[31:26];
	endfunction

	// Update the stored filter for one accepted transaction and queue the report.
	// Lists over the limit leave the filter alone; an empty list hashes nothing.
	task automatic predict_filter_update(item_t it);
		logic [5:0] idx;
		logic over;
		logic [63:0] eff;
		result_t rep;
		idx = crc_hash_index(it.address);
		over = it.list_count > limit_setting;
		if (!over && it.list_count != 0) begin
			filter_bits = filter_bits | (64'd1 << idx);
		end
		// Promiscuous mode only masks the report; the stored filter keeps going
		eff = (over || promisc_mode) ? '1 : filter_bits;
		rep.hash_index = idx;
		rep.filter_low = eff[31:0];
		rep.filter_high = eff[63:32];
		rep.all_accepted = over || promisc_mode;
		pending_reports.push_back(rep);
	endtask

	// Driver: hold the payload while stalled, advance from the queue otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_filter_update(item);
			end
			if (!item_valid || !item_stall) begin
				if (queued_addresses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_valid <= 1'b1;
					item <= queued_addresses.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_reports.size() == 0) begin
					failures++;
					if (failures <= SHOWN_MISMATCHES) begin
						$display("unexpected result: idx %0d lo %08h hi %08h all %0b",
							result.hash_index, result.filter_low, result.filter_high,
							result.all_accepted);
					end
				end else begin
					want = pending_reports.pop_front();
					if (result.hash_index !== want.hash_index
							|| result.filter_low !== want.filter_low
							|| result.filter_high !== want.filter_high
							|| result.all_accepted !== want.all_accepted) begin
						failures++;
						if (failures <= SHOWN_MISMATCHES) begin
							$display("mismatch: expected idx %0d lo %08h hi %08h all %0b",
								want.hash_index, want.filter_low, want.filter_high,
								want.all_accepted);
							$display("          actual   idx %0d lo %08h hi %08h all %0b",
								result.hash_index, result.filter_low, result.filter_high,
								result.all_accepted);
						end
					end
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: drop the run if the handshakes never finish
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("multicast_hash_filter_builder regression: fail");
			$finish;
		end
	end

	task automatic push_address(logic [47:0] mac, logic [11:0] count);
		item_t it;
		it.address = mac;
		it.list_count = count;
		queued_addresses.push_back(it);
	endtask

	// Wait until every queued transaction went in and every report came out;
	// sample mid-cycle so the driver and monitor updates have settled
	task automatic wait_drained();
		while (queued_addresses.size() != 0 || item_valid || pending_reports.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Write one register while idle and mirror it in the predictor
	task automatic program_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_FILTER_LIMIT: limit_setting = value[11:0];
			REG_ACCEPT_ALL: promisc_mode = value[0];
			default: ;
		endcase
	endtask

	// List lengths cluster around the current limit to hit both sides of it
	function automatic logic [11:0] pick_list_count();
		case ($urandom_range(6))
			0: return 12'd0;
			1: return limit_setting;
			2: return limit_setting + 12'd1;
			3: return 12'hFFF;
			4: return 12'($urandom_range(limit_setting));
			default: return 12'($urandom);
		endcase
	endfunction

	// Mix of raw random, multicast-flagged, IPv4-mapped and repeated addresses
	function automatic logic [47:0] pick_address();
		logic [47:0] mac;
		mac = {16'($urandom), 32'($urandom)};
		case ($urandom_range(3))
			0: ;
			1: mac[0] = 1'b1;
			2: mac = {25'($urandom) & 25'h7F_FFFF, 23'h00_5E01} ;
			default: mac = last_address;
		endcase
		return mac;
	endfunction

	task automatic queue_random(int unsigned n);
		logic [47:0] mac;
		for (int unsigned i = 0; i < n; i++) begin
			mac = pick_address();
			last_address = mac;
			push_address(mac, pick_list_count());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset limit of 32, edges of address and list length
		push_address(48'h0000_0000_0000, 12'd1);
		push_address(48'hFFFF_FFFF_FFFF, 12'd32);
		push_address(48'h0100_5E00_0001, 12'd1);
		push_address(48'h3333_0000_0001, 12'd5);
		push_address(48'h0180_C200_0000, 12'd0);
		push_address(48'hFFFF_FFFF_FFFF, 12'd33);
		push_address(48'h0000_0000_0000, 12'hFFF);
		push_address(48'h0000_0000_0001, 12'd31);
		push_address(48'h8000_0000_0000, 12'd2);
		push_address(48'h5555_5555_5555, 12'd3);
		push_address(48'hAAAA_AAAA_AAAA, 12'd4);
		push_address(48'h0000_0100_0000, 12'd32);
		push_address(48'h0100_5E7F_FFFF, 12'd0);
		push_address(48'h0000_0000_8000, 12'd7);
		wait_drained();

		// Limit zero: any nonempty list is over, so the filter stays put
		program_register(REG_FILTER_LIMIT, 12'd0);
		send_idle_pct = 48;
		queue_random(125);
		wait_drained();

		// Promiscuous on, with junk in the unused data bits
		program_register(REG_ACCEPT_ALL, 12'hFFF);
		send_idle_pct = 0;
		recv_stall_pct = 48;
		push_address(48'h0100_5E7F_FFFF, 12'd0);
		push_address(48'h0100_5E12_3456, 12'd1);
		push_address(48'hFFFF_FFFF_FFFF, 12'hFFF);
		push_address(48'h0000_0000_0000, 12'd0);
		queue_random(60);
		// Hold the sender until every report is back
		wait_drained();
		queue_random(65);
		wait_drained();

		// Promiscuous off (upper data bits set), limit one
		program_register(REG_ACCEPT_ALL, 12'hFFE);
		program_register(REG_FILTER_LIMIT, 12'd1);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		queue_random(125);
		wait_drained();

		program_register(REG_FILTER_LIMIT, 12'($urandom_range(2, 4094)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(125);
		wait_drained();

		// Largest limit: no list is over, the filter fills up
		program_register(REG_FILTER_LIMIT, 12'hFFF);
		send_idle_pct = 48;
		queue_random(125);
		wait_drained();

		program_register(REG_FILTER_LIMIT, 12'd32);
		send_idle_pct = 0;
		recv_stall_pct = 48;
		queue_random(125);
		wait_drained();

		// Let any stray result surface before judging
		repeat (6) @(posedge clk);
		if (failures == 0) begin
			$display("multicast_hash_filter_builder regression: pass");
		end else begin
			$display("multicast_hash_filter_builder regression: fail");
		end
		$finish;
	end

endmodule
